### hw/rtl/tcge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcge_pkg;

  // text grid
  localparam int TEXT_COLUMNS = 21;
  localparam int TEXT_ROWS    = 8;
  localparam int COL_W        = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
  localparam int ROW_W        = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

  localparam int CELL_WIDTH = 6;
  localparam int FONT_WIDTH = 5;
  localparam int GLYPHS     = 43;
  localparam int GLYPH_W    = $clog2(GLYPHS);
  localparam int FCOL_W     = $clog2(FONT_WIDTH);

  // input commands and special characters
  localparam logic       CMD_PRINT      = 1'b0;
  localparam logic       CMD_SET_CURSOR = 1'b1;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

  // controller opcodes
  localparam logic [7:0] OP_COLUMN_WINDOW = 8'h21;
  localparam logic [7:0] OP_PAGE_WINDOW   = 8'h22;
  localparam logic [7:0] BLANK_COLUMN     = 8'h00;

  // byte slots inside one character sequence
  localparam int         SLOTS        = 12;
  localparam int         SLOT_W       = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_COL_OP    = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_COL_START = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_COL_END   = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_PAGE_OP   = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_PAGE_LO   = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_PAGE_HI   = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_DATA0     = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] SLOT_DATA1     = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] SLOT_DATA2     = SLOT_W'(8);
  localparam logic [SLOT_W-1:0] SLOT_DATA3     = SLOT_W'(9);
  localparam logic [SLOT_W-1:0] SLOT_DATA4     = SLOT_W'(10);
  localparam logic [SLOT_W-1:0] SLOT_BLANK     = SLOT_W'(11);

  // glyph indexes
  localparam int G_SPACE    = 0;
  localparam int G_QUERY    = 1;
  localparam int G_DOT      = 2;
  localparam int G_COLON    = 3;
  localparam int G_MINUS    = 4;
  localparam int G_SLASH    = 5;
  localparam int G_PERCENT  = 6;
  localparam int G_DIGIT0   = 7;
  localparam int G_LETTER_A = 17;

  localparam logic [7:0] FONT [GLYPHS][FONT_WIDTH] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
    '{8'h63, 8'h13, 8'h08, 8'h64, 8'h63},
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  // character code to glyph index, lowercase folded, unknown to question mark
  function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] code);
    logic [7:0]         c;
    logic [GLYPH_W-1:0] g;
    c = code;
    if (c >= 8'd97 && c <= 8'd122) begin
      c = c - 8'd32;
    end
    if (c >= 8'd48 && c <= 8'd57) begin
      g = GLYPH_W'(G_DIGIT0) + GLYPH_W'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd90) begin
      g = GLYPH_W'(G_LETTER_A) + GLYPH_W'(c - 8'd65);
    end else if (c == 8'd32) begin
      g = GLYPH_W'(G_SPACE);
    end else if (c == 8'd46) begin
      g = GLYPH_W'(G_DOT);
    end else if (c == 8'd58) begin
      g = GLYPH_W'(G_COLON);
    end else if (c == 8'd45 || c == 8'd95) begin
      g = GLYPH_W'(G_MINUS);
    end else if (c == 8'd47) begin
      g = GLYPH_W'(G_SLASH);
    end else if (c == 8'd37) begin
      g = GLYPH_W'(G_PERCENT);
    end else begin
      g = GLYPH_W'(G_QUERY);
    end
    return g;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/text_cursor_glyph_emitter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// input     in         in_valid_i / in_stall_o   cmd_i, char_code_i, column_setting_i,
//                                                row_setting_i
// output    out        out_valid_o / out_stall_i out_byte_o, is_data_o, last_o
// config    in         cfg_we_i                  cfg_wdata_i (enable)
//
// a printed character holds the job register while its bytes go out, one byte per
// cycle unless the output stalls, out of the 12-slot byte sequencer; the next item
// is taken in the cycle the last byte moves to the output register.
// cursor moves, newlines and ignored prints make no bytes and open no job.
// reset clears the cursor, enable and all valid flags; an output stall freezes
// the byte sequencer and, once the job is open, the input side.

module text_cursor_glyph_emitter (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic                 cmd_i,
  input  wire logic [7:0]           char_code_i,
  input  wire logic [7:0]           column_setting_i,
  input  wire logic [7:0]           row_setting_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [7:0]           out_byte_o,
  output      logic                 is_data_o,
  output      logic                 last_o,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i
);
  import tcge_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
  localparam logic [7:0]       COLS_B   = 8'(TEXT_COLUMNS);
  localparam logic [7:0]       ROWS_B   = 8'(TEXT_ROWS);

  // configuration and cursor
  logic             enable_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // open print job
  logic               job_busy_q, job_busy_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [7:0]         start_q;
  logic [ROW_W-1:0]   job_row_q;
  logic [GLYPH_W-1:0] glyph_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       is_data_q, last_q;

  logic       accept, is_print, advance, job_done;
  logic [7:0] start_d;
  logic [7:0] byte_sel;
  logic       data_sel;
  logic [FCOL_W-1:0] font_col;
  logic [ROW_W-1:0]  row_next;

  // the sequencer moves a byte whenever the output register is free
  assign advance  = job_busy_q && (!out_valid_q || !out_stall_i);
  assign job_done = advance && (slot_q == SLOT_BLANK);
  assign in_stall_o = job_busy_q && !job_done;
  assign accept   = in_valid_i && !in_stall_o;
  assign is_print = (cmd_i == CMD_PRINT) && enable_q && (char_code_i != CHAR_NEWLINE);

  // pixel column of the current cell, kept to a byte
  assign start_d  = 8'({{(8 - COL_W){1'b0}}, col_q} * 8'(CELL_WIDTH));
  // row advance sticks at the last row
  assign row_next = (row_q == LAST_ROW) ? row_q : row_q + ROW_W'(1);

  // cursor update for the item being accepted
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (cmd_i == CMD_SET_CURSOR) begin
        col_d = (column_setting_i < COLS_B) ? column_setting_i[COL_W-1:0] : LAST_COL;
        row_d = (row_setting_i < ROWS_B) ? row_setting_i[ROW_W-1:0] : LAST_ROW;
      end else if (enable_q && char_code_i == CHAR_NEWLINE) begin
        col_d = '0;
        row_d = row_next;
      end else if (enable_q) begin
        // printed: step right, wrap at line end
        if (col_q == LAST_COL) begin
          col_d = '0;
          row_d = row_next;
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    job_busy_d = job_busy_q;
    slot_d     = slot_q;
    if (accept && is_print) begin
      job_busy_d = 1'b1;
      slot_d     = SLOT_COL_OP;
    end else if (job_done) begin
      job_busy_d = 1'b0;
    end else if (advance) begin
      slot_d = slot_q + SLOT_W'(1);
    end
  end

  // byte of the current slot
  assign font_col = FCOL_W'(slot_q - SLOT_DATA0);
  always_comb begin
    byte_sel = BLANK_COLUMN;
    data_sel = 1'b1;
    unique case (slot_q)
      SLOT_COL_OP: begin
        byte_sel = OP_COLUMN_WINDOW;
        data_sel = 1'b0;
      end
      SLOT_COL_START: begin
        byte_sel = start_q;
        data_sel = 1'b0;
      end
      SLOT_COL_END: begin
        byte_sel = start_q + 8'(CELL_WIDTH - 1);
        data_sel = 1'b0;
      end
      SLOT_PAGE_OP: begin
        byte_sel = OP_PAGE_WINDOW;
        data_sel = 1'b0;
      end
      SLOT_PAGE_LO, SLOT_PAGE_HI: begin
        byte_sel = 8'(job_row_q);
        data_sel = 1'b0;
      end
      SLOT_DATA0, SLOT_DATA1, SLOT_DATA2, SLOT_DATA3, SLOT_DATA4: begin
        byte_sel = FONT[glyph_q][font_col];
      end
      default: begin
        byte_sel = BLANK_COLUMN;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      job_busy_q  <= 1'b0;
      slot_q      <= SLOT_COL_OP;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      col_q       <= col_d;
      row_q       <= row_d;
      job_busy_q  <= job_busy_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && is_print) begin
      start_q   <= start_d;
      job_row_q <= row_q;
      glyph_q   <= glyph_index(char_code_i);
    end
    if (advance) begin
      out_byte_q <= byte_sel;
      is_data_q  <= data_sel;
      last_q     <= (slot_q == SLOT_BLANK);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_data_o   = is_data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tcge_pkg::*;

  // run ends here even if the block hangs
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // items per random phase, four phases
  localparam int unsigned PHASE_ITEMS  = 103;
  // idle cycles allowed after the last byte before a register write or the verdict
  localparam int unsigned SETTLE_CYCLES = 8;

  // font kept here independently of the rtl rom: five columns per glyph,
  // leftmost column in the top byte
  localparam logic [39:0] GLYPH_COLS [43] = '{
    40'h00_00_00_00_00, 40'h02_01_51_09_06, 40'h00_60_60_00_00, 40'h00_36_36_00_00,
    40'h08_08_08_08_08, 40'h20_10_08_04_02, 40'h63_13_08_64_63, 40'h3E_51_49_45_3E,
    40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31, 40'h18_14_12_7F_10,
    40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
    40'h06_49_49_29_1E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  // one byte headed for the display controller
  typedef struct packed {
    logic [7:0] ctrl_byte;
    logic       is_data;
    logic       last;
  } oled_byte_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic       cmd_i            = CMD_PRINT;
  logic [7:0] char_code_i      = 8'h00;
  logic [7:0] column_setting_i = 8'h00;
  logic [7:0] row_setting_i    = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       last_o;
  logic       cfg_we_i         = 1'b0;
  logic       cfg_wdata_i      = 1'b0;

  // bytes the display should still receive, oldest first
  oled_byte_t       oled_bytes_q[$];
  // shadow of the block's cursor and enable register
  logic [COL_W-1:0] track_col = '0;
  logic [ROW_W-1:0] track_row = '0;
  logic             display_on = 1'b0;

  // idling knobs, percent of cycles
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned mismatches      = 0;

  // characters that have a real glyph, lowercase included to hit the fold
  string glyph_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 .:-_/%";

  text_cursor_glyph_emitter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .char_code_i      (char_code_i),
    .column_setting_i (column_setting_i),
    .row_setting_i    (row_setting_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .is_data_o        (is_data_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // character code to font slot: lowercase folds up, underscore shares minus,
  // anything without a glyph gets the question mark
  function automatic int unsigned font_slot(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    if (c >= "0" && c <= "9") begin
      return G_DIGIT0 + int'(c - "0");
    end
    if (c >= "A" && c <= "Z") begin
      return G_LETTER_A + int'(c - "A");
    end
    case (c)
      " ":      return G_SPACE;
      ".":      return G_DOT;
      ":":      return G_COLON;
      "-", "_": return G_MINUS;
      "/":      return G_SLASH;
      "%":      return G_PERCENT;
      default:  return G_QUERY;
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic data, input logic fin);
    oled_byte_t ob;
    ob.ctrl_byte = b;
    ob.is_data   = data;
    ob.last      = fin;
    oled_bytes_q.push_back(ob);
  endfunction

  // row advance sticks on the bottom row
  function automatic void next_text_row();
    if (track_row + 1 < TEXT_ROWS) begin
      track_row = track_row + 1'b1;
    end
  endfunction

  // cursor update and byte sequence for one accepted item
  function automatic void predict_oled_bytes(input logic c, input logic [7:0] code,
                                             input logic [7:0] col, input logic [7:0] row);
    logic [7:0]  start_px;
    logic [39:0] cols;
    if (c == CMD_SET_CURSOR) begin
      // cursor set saturates and ignores enable
      track_col = (col < TEXT_COLUMNS) ? COL_W'(col) : COL_W'(TEXT_COLUMNS - 1);
      track_row = (row < TEXT_ROWS) ? ROW_W'(row) : ROW_W'(TEXT_ROWS - 1);
      return;
    end
    if (!display_on) begin
      return;
    end
    if (code == CHAR_NEWLINE) begin
      track_col = '0;
      next_text_row();
      return;
    end
    start_px = 8'(track_col * CELL_WIDTH);
    cols     = GLYPH_COLS[font_slot(code)];
    push_byte(OP_COLUMN_WINDOW, 1'b0, 1'b0);
    push_byte(start_px, 1'b0, 1'b0);
    push_byte(8'(start_px + CELL_WIDTH - 1), 1'b0, 1'b0);
    push_byte(OP_PAGE_WINDOW, 1'b0, 1'b0);
    push_byte(8'(track_row), 1'b0, 1'b0);
    push_byte(8'(track_row), 1'b0, 1'b0);
    for (int i = 0; i < FONT_WIDTH; i++) begin
      push_byte(cols[39 - 8 * i -: 8], 1'b1, 1'b0);
    end
    push_byte(BLANK_COLUMN, 1'b1, 1'b1);
    // advance, wrapping at the line end
    if (track_col + 1 < TEXT_COLUMNS) begin
      track_col = track_col + 1'b1;
    end else begin
      track_col = '0;
      next_text_row();
    end
  endfunction

  // output check: every accepted byte against the oldest expected one
  always @(posedge clk_i) begin : check_bytes
    oled_byte_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (oled_bytes_q.size() == 0) begin
        $error("unexpected byte %0h (is_data %0b, last %0b)", out_byte_o, is_data_o, last_o);
        mismatches++;
      end else begin
        want = oled_bytes_q.pop_front();
        if (out_byte_o !== want.ctrl_byte) begin
          $error("out_byte: expected %0h, got %0h", want.ctrl_byte, out_byte_o);
          mismatches++;
        end
        if (is_data_o !== want.is_data) begin
          $error("is_data: expected %0b, got %0b", want.is_data, is_data_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("text_cursor_glyph_emitter test failed");
    $finish;
  end

  // send one item; valid is left high after acceptance so back-to-back items
  // never lower and raise it in the same step
  task automatic send_item(input logic c, input logic [7:0] code,
                           input logic [7:0] col, input logic [7:0] row);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= c;
    char_code_i      <= code;
    column_setting_i <= col;
    row_setting_i    <= row;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) begin
      @(posedge clk_i);
    end
    predict_oled_bytes(c, code, col, row);
  endtask

  task automatic print_char(input logic [7:0] code);
    send_item(CMD_PRINT, code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic move_cursor(input logic [7:0] col, input logic [7:0] row);
    send_item(CMD_SET_CURSOR, 8'($urandom_range(0, 255)), col, row);
  endtask

  // drop valid, wait for every expected byte, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (oled_bytes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever called with the block idle
  task automatic write_enable(input logic en);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    display_on  = en;
  endtask

  // mostly real text with random cursor jumps and newlines, plus raw byte noise
  task automatic random_item();
    int unsigned pick;
    logic [7:0]  col;
    logic [7:0]  row;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      col = $urandom_range(0, 1) ? 8'($urandom_range(0, TEXT_COLUMNS - 1))
                                 : 8'($urandom_range(0, 255));
      row = $urandom_range(0, 1) ? 8'($urandom_range(0, TEXT_ROWS - 1))
                                 : 8'($urandom_range(0, 255));
      move_cursor(col, row);
    end else if (pick < 18) begin
      print_char(CHAR_NEWLINE);
    end else if (pick < 65) begin
      print_char(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)]);
    end else begin
      print_char(8'($urandom_range(0, 255)));
    end
  endtask

  // enable clear after reset: prints and newlines vanish, cursor sets still land
  task automatic test_disabled_after_reset();
    print_char("A");
    print_char(CHAR_NEWLINE);
    move_cursor(8'd255, 8'd255);
    print_char("Z");
    move_cursor(8'd3, 8'd2);
    print_char(8'hFF);
    wait_idle();
  endtask

  // every glyph class, fold, unknown codes, wrap and bottom-row stick
  task automatic test_glyph_classes();
    write_enable(1'b1);
    move_cursor(8'd0, 8'd0);
    print_char("A");
    print_char("z");
    print_char("_");
    print_char("-");
    print_char("0");
    print_char("9");
    print_char(" ");
    print_char(".");
    print_char(":");
    print_char("/");
    print_char("%");
    print_char(8'h00);
    print_char(8'h80);
    print_char(8'hFF);
    print_char(CHAR_NEWLINE);
    // last cell of the first line wraps onto the next row
    move_cursor(8'(TEXT_COLUMNS - 1), 8'd0);
    print_char("M");
    // out-of-range set clamps to the bottom-right cell, then wrap sticks on the last row
    move_cursor(8'd255, 8'd255);
    print_char("Q");
    print_char("W");
    print_char(CHAR_NEWLINE);
    print_char("?");
    wait_idle();
  endtask

  // enable cleared again mid-run, random traffic must stay silent
  task automatic test_enable_toggle();
    write_enable(1'b0);
    repeat (20) random_item();
    wait_idle();
    write_enable(1'b1);
  endtask

  // random traffic under the four idling mixes
  task automatic test_random_traffic();
    int unsigned sender_mix[4] = '{0, 77, 0, 22};
    int unsigned recv_mix[4]   = '{0, 0, 77, 22};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = sender_mix[p];
      recv_stall_pct  = recv_mix[p];
      repeat (PHASE_ITEMS) random_item();
      wait_idle();
    end
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_after_reset();
    test_glyph_classes();
    test_enable_toggle();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0) begin
      $display("text_cursor_glyph_emitter test passed");
    end else begin
      $display("text_cursor_glyph_emitter test failed");
    end
    $finish;
  end

endmodule
